// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// label: assertion clocked on clk, disabled while rst is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
    label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// label: assertion that also runs during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== design/tmh_pkg.sv =====
// Package: codes, states and constants of the timer min-heap scheduler
`timescale 1ns / 1ps
package tmh_pkg;
    localparam int DEFAULT_CAPACITY = 64;
    localparam int DEFAULT_TAG_BITS = 32;
    localparam int TICK_W           = 48;
    localparam int HANDLER_W        = 8;
    localparam int HELD_W           = 7;
    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_TICK   = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_DONE     = 3'd0,
        ST_FULL     = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_NODUE    = 3'd4,
        ST_FIRED    = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE, S_UP, S_UP_W, S_RM_LAST_W, S_SR_RD, S_SR_W, S_TK_W,
        S_LAST_W, S_DN, S_DN_L_W, S_DN_R_W, S_DN_CMP, S_FIN
    } state_t;

    typedef struct packed {
        logic we;
        logic re;
    } mem_ctl_t;
endpackage

// ===== design/tmh_mem.sv =====
// Heap entry memory: one write port, one read port, registered read data
`timescale 1ns / 1ps
module tmh_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int EW    = 88
) (
    input  logic             aclk,
    input  tmh_pkg::mem_ctl_t ctl,
    input  logic [AW-1:0]    waddr,
    input  logic [EW-1:0]    wdata,
    input  logic [AW-1:0]    raddr,
    output logic [EW-1:0]    rdata
);
    import tmh_pkg::*;

    logic [EW-1:0] mem [DEPTH];
    logic [EW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (ctl.we) begin
            mem[waddr] <= wdata;
        end
        if (ctl.re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== design/tmh_ctrl.sv =====
// Heap sequencer: insert, search, sift up and down over the entry memory
`timescale 1ns / 1ps
module tmh_ctrl #(
    parameter int CAPACITY = 64,
    parameter int TAG_BITS = 32,
    parameter int AW       = 6,
    parameter int EW       = 88
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  tmh_pkg::func_t              s_func,
    input  logic [31:0]                 s_delay,
    input  logic [31:0]                 s_tag,
    input  logic [tmh_pkg::HANDLER_W-1:0] s_handler,
    output logic                        m_valid,
    input  logic                        m_ready,
    output tmh_pkg::status_t            m_status,
    output logic [31:0]                 m_ftag,
    output logic [tmh_pkg::HANDLER_W-1:0] m_fhand,
    output logic [tmh_pkg::TICK_W-1:0]  m_remain,
    output logic [tmh_pkg::HELD_W-1:0]  m_held,
    output tmh_pkg::mem_ctl_t           mem_ctl,
    output logic [AW-1:0]               mem_waddr,
    output logic [EW-1:0]               mem_wdata,
    output logic [AW-1:0]               mem_raddr,
    input  logic [EW-1:0]               mem_rdata
);
    import tmh_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int DW = AW + 1;

    state_t state_reg, state_next;
    logic [TICK_W-1:0]    now_reg, now_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [AW-1:0]        idx_reg, idx_next, cidx_reg, cidx_next;
    logic [TICK_W-1:0]    cur_dl_reg, cur_dl_next;
    logic [TAG_BITS-1:0]  cur_tag_reg, cur_tag_next, key_reg, key_next;
    logic [HANDLER_W-1:0] cur_h_reg, cur_h_next;
    logic [EW-1:0]        chl_reg, chl_next;
    status_t              st_reg, st_next;
    logic [31:0]          ftag_reg, ftag_next;
    logic [HANDLER_W-1:0] fh_reg, fh_next;
    logic [TICK_W-1:0]    rem_reg, rem_next;
    logic                 mv_reg, mv_next;
    status_t              ms_reg, ms_next;
    logic [31:0]          mt_reg, mt_next;
    logic [HANDLER_W-1:0] mh_reg, mh_next;
    logic [TICK_W-1:0]    mr_reg, mr_next;
    logic [HELD_W-1:0]    me_reg, me_next;

    logic [TICK_W-1:0]    rd_dl, chl_dl;
    logic [TAG_BITS-1:0]  rd_tag, in_tag;
    logic [HANDLER_W-1:0] rd_h;
    logic [TICK_W:0]      dl_sum;
    logic [AW-1:0]        parent, last_idx;
    logic [DW-1:0]        child, cnt_ext;

    assign rd_dl   = mem_rdata[TICK_W-1:0];
    assign rd_tag  = mem_rdata[TICK_W +: TAG_BITS];
    assign rd_h    = mem_rdata[TICK_W+TAG_BITS +: HANDLER_W];
    assign chl_dl  = chl_reg[TICK_W-1:0];
    assign in_tag  = TAG_BITS'(s_tag);
    assign dl_sum  = {1'b0, now_reg} + (TICK_W+1)'(s_delay);
    assign parent  = (idx_reg - 1'b1) >> 1;
    assign last_idx = AW'(cnt_reg - 1'b1);
    assign child   = {idx_reg, 1'b1};
    assign cnt_ext = DW'(cnt_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            now_reg   <= '0;
            cnt_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            now_reg   <= now_next;
            cnt_reg   <= cnt_next;
            mv_reg    <= mv_next;
        end
        idx_reg     <= idx_next;
        cidx_reg    <= cidx_next;
        cur_dl_reg  <= cur_dl_next;
        cur_tag_reg <= cur_tag_next;
        cur_h_reg   <= cur_h_next;
        key_reg     <= key_next;
        chl_reg     <= chl_next;
        st_reg      <= st_next;
        ftag_reg    <= ftag_next;
        fh_reg      <= fh_next;
        rem_reg     <= rem_next;
        ms_reg      <= ms_next;
        mt_reg      <= mt_next;
        mh_reg      <= mh_next;
        mr_reg      <= mr_next;
        me_reg      <= me_next;
    end

    always_comb begin
        state_next   = state_reg;
        now_next     = now_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        cidx_next    = cidx_reg;
        cur_dl_next  = cur_dl_reg;
        cur_tag_next = cur_tag_reg;
        cur_h_next   = cur_h_reg;
        key_next     = key_reg;
        chl_next     = chl_reg;
        st_next      = st_reg;
        ftag_next    = ftag_reg;
        fh_next      = fh_reg;
        rem_next     = rem_reg;
        mv_next      = mv_reg & ~m_ready;
        ms_next      = ms_reg;
        mt_next      = mt_reg;
        mh_next      = mh_reg;
        mr_next      = mr_reg;
        me_next      = me_reg;
        mem_ctl      = '0;
        mem_waddr    = idx_reg;
        mem_wdata    = {cur_h_reg, cur_tag_reg, cur_dl_reg};
        mem_raddr    = parent;
        s_ready      = (state_reg == S_IDLE);

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    st_next   = ST_DONE;
                    ftag_next = '0;
                    fh_next   = '0;
                    rem_next  = '0;
                    key_next  = in_tag;
                    state_next = S_FIN;
                    unique case (s_func)
                        FUNC_INSERT: begin
                            if (cnt_reg >= CW'(CAPACITY)) begin
                                st_next = ST_FULL;
                            end else begin
                                cur_dl_next  = dl_sum[TICK_W] ? TICK_MAX : dl_sum[TICK_W-1:0];
                                cur_tag_next = in_tag;
                                cur_h_next   = s_handler;
                                idx_next     = AW'(cnt_reg);
                                cnt_next     = cnt_reg + 1'b1;
                                state_next   = S_UP;
                            end
                        end
                        FUNC_REMOVE: begin
                            if (cnt_reg == '0) begin
                                st_next = ST_EMPTY;
                            end else begin
                                mem_ctl.re = 1'b1;
                                mem_raddr  = last_idx;
                                state_next = S_RM_LAST_W;
                            end
                        end
                        FUNC_TICK: begin
                            now_next = now_reg + 1'b1;
                            if (cnt_reg == '0) begin
                                st_next = ST_EMPTY;
                            end else begin
                                mem_ctl.re = 1'b1;
                                mem_raddr  = '0;
                                state_next = S_TK_W;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_UP: begin
                if (idx_reg == '0) begin
                    mem_ctl.we = 1'b1;
                    state_next = S_FIN;
                end else begin
                    mem_ctl.re = 1'b1;
                    mem_raddr  = parent;
                    state_next = S_UP_W;
                end
            end
            S_UP_W: begin
                mem_ctl.we = 1'b1;
                if (rd_dl < cur_dl_reg) begin
                    state_next = S_FIN;
                end else begin
                    // pull the parent down and climb
                    mem_wdata  = mem_rdata;
                    idx_next   = parent;
                    state_next = S_UP;
                end
            end
            S_RM_LAST_W: begin
                cur_dl_next  = rd_dl;
                cur_tag_next = rd_tag;
                cur_h_next   = rd_h;
                if (rd_tag == key_reg) begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = S_FIN;
                end else begin
                    st_next    = ST_NOTFOUND;
                    idx_next   = '0;
                    state_next = S_SR_RD;
                end
            end
            S_SR_RD: begin
                mem_ctl.re = 1'b1;
                mem_raddr  = idx_reg;
                state_next = S_SR_W;
            end
            S_SR_W: begin
                if (rd_tag == key_reg) begin
                    st_next  = ST_DONE;
                    cnt_next = cnt_reg - 1'b1;
                    state_next = (DW'(idx_reg) == DW'(cnt_reg - 1'b1)) ? S_FIN : S_DN;
                end else if (DW'(idx_reg) + 1'b1 >= cnt_ext) begin
                    state_next = S_FIN;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SR_RD;
                end
            end
            S_TK_W: begin
                if (rd_dl <= now_reg) begin
                    st_next   = ST_FIRED;
                    ftag_next = 32'(rd_tag);
                    fh_next   = rd_h;
                    cnt_next  = cnt_reg - 1'b1;
                    if (cnt_reg == CW'(1)) begin
                        state_next = S_FIN;
                    end else begin
                        mem_ctl.re = 1'b1;
                        mem_raddr  = last_idx;
                        state_next = S_LAST_W;
                    end
                end else begin
                    st_next    = ST_NODUE;
                    rem_next   = rd_dl - now_reg;
                    state_next = S_FIN;
                end
            end
            S_LAST_W: begin
                cur_dl_next  = rd_dl;
                cur_tag_next = rd_tag;
                cur_h_next   = rd_h;
                idx_next     = '0;
                state_next   = S_DN;
            end
            S_DN: begin
                if (child >= cnt_ext) begin
                    state_next = S_UP;
                end else begin
                    mem_ctl.re = 1'b1;
                    mem_raddr  = child[AW-1:0];
                    cidx_next  = child[AW-1:0];
                    state_next = S_DN_L_W;
                end
            end
            S_DN_L_W: begin
                chl_next = mem_rdata;
                if (DW'(cidx_reg) + 1'b1 < cnt_ext) begin
                    mem_ctl.re = 1'b1;
                    mem_raddr  = cidx_reg + 1'b1;
                    state_next = S_DN_R_W;
                end else begin
                    state_next = S_DN_CMP;
                end
            end
            S_DN_R_W: begin
                if (rd_dl < chl_dl) begin
                    chl_next  = mem_rdata;
                    cidx_next = cidx_reg + 1'b1;
                end
                state_next = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (cur_dl_reg < chl_dl) begin
                    state_next = S_UP;
                end else begin
                    mem_ctl.we = 1'b1;
                    mem_wdata  = chl_reg;
                    idx_next   = cidx_reg;
                    state_next = S_DN;
                end
            end
            S_FIN: begin
                // hold until the output register is free
                if (!mv_reg || m_ready) begin
                    mv_next    = 1'b1;
                    ms_next    = st_reg;
                    mt_next    = ftag_reg;
                    mh_next    = fh_reg;
                    mr_next    = rem_reg;
                    me_next    = HELD_W'(cnt_reg);
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign m_valid  = mv_reg;
    assign m_status = ms_reg;
    assign m_ftag   = mt_reg;
    assign m_fhand  = mh_reg;
    assign m_remain = mr_reg;
    assign m_held   = me_reg;
endmodule

// ===== design/timer_min_heap_scheduler_unit.sv =====
// Timer min-heap scheduler: top level with stream ports
// Insert climbs past each parent whose deadline is not lower; a full heap refuses it.
// Tick fires the root when due, moves the last entry to the root, sinks it and climbs;
// remove drops the last entry when its tag matches, else searches the entries in order
// and sifts after a deletion.
// Rate: one item at a time; an output register lets the next beat enter while a result waits.
// Reset (aresetn low, synchronous) clears time, entry count and the output valid.
`timescale 1ns / 1ps
module timer_min_heap_scheduler_unit #(
    parameter int CAPACITY = tmh_pkg::DEFAULT_CAPACITY,
    parameter int TAG_BITS = tmh_pkg::DEFAULT_TAG_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // delay_ticks[31:0], task_tag[63:32], handler_id[71:64]
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // fired_tag[31:0], fired_handler[39:32],
                                   // ticks_remaining[87:40], entries_held[94:88], zero
    output logic [2:0]  m_tuser    // status[2:0]
);
    import tmh_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int EW = TICK_W + TAG_BITS + HANDLER_W;

    mem_ctl_t             mem_ctl;
    logic [AW-1:0]        mem_waddr, mem_raddr;
    logic [EW-1:0]        mem_wdata, mem_rdata;
    status_t              m_status;
    logic [31:0]          m_ftag;
    logic [HANDLER_W-1:0] m_fhand;
    logic [TICK_W-1:0]    m_remain;
    logic [HELD_W-1:0]    m_held;

    tmh_ctrl #(.CAPACITY(CAPACITY), .TAG_BITS(TAG_BITS), .AW(AW), .EW(EW)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_tvalid), .s_ready(s_tready), .s_func(func_t'(s_tuser)),
        .s_delay(s_tdata[31:0]), .s_tag(s_tdata[63:32]), .s_handler(s_tdata[71:64]),
        .m_valid(m_tvalid), .m_ready(m_tready), .m_status(m_status),
        .m_ftag(m_ftag), .m_fhand(m_fhand), .m_remain(m_remain), .m_held(m_held),
        .mem_ctl(mem_ctl), .mem_waddr(mem_waddr), .mem_wdata(mem_wdata),
        .mem_raddr(mem_raddr), .mem_rdata(mem_rdata)
    );

    tmh_mem #(.DEPTH(CAPACITY), .AW(AW), .EW(EW)) u_mem (
        .aclk(aclk), .ctl(mem_ctl), .waddr(mem_waddr), .wdata(mem_wdata),
        .raddr(mem_raddr), .rdata(mem_rdata)
    );

    assign m_tdata = {1'b0, m_held, m_remain, m_fhand, m_ftag};
    assign m_tuser = m_status;
endmodule

// ===== design/tmh_checker.sv =====
// Port checker for the timer min-heap scheduler, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tmh_checker #(
    parameter int CAPACITY = 64
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic [2:0]  m_tuser
);
    import tmh_pkg::*;

    `ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_tvalid, "output valid after reset")
    `ASSERT_CLK(a_out_holds, aclk, !aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled beat dropped")
    `ASSERT_CLK(a_held_bound, aclk, !aresetn, m_tvalid |-> m_tdata[94:88] <= 7'(CAPACITY) && m_tuser <= ST_FIRED, "bad held count or status")
    `ASSERT_CLK(a_remain_only_nodue, aclk, !aresetn, m_tvalid && m_tuser != ST_NODUE |-> m_tdata[87:40] == '0, "remaining ticks without nothing due")
    `ASSERT_CLK(a_fired_fields, aclk, !aresetn, m_tvalid && m_tuser != ST_FIRED |-> m_tdata[39:0] == '0, "fired fields set without a fire")
endmodule

bind timer_min_heap_scheduler_unit tmh_checker #(.CAPACITY(CAPACITY)) u_tmh_checker (
    .aclk(aclk), .aresetn(aresetn), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser)
);

// ===== tb/sv/timer_min_heap_scheduler_unit_test.sv =====
// Testbench: timer min-heap scheduler checked beat by beat against a local heap predictor
`timescale 1ns / 1ps
module timer_min_heap_scheduler_unit_test;
    import tmh_pkg::*;

    localparam int CAP        = DEFAULT_CAPACITY;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [2:0]        status;
        logic [31:0]       tag;
        logic [7:0]        hand;
        logic [TICK_W-1:0] remain;
        logic [HELD_W-1:0] held;
    } timer_result_t;

    typedef struct {
        func_t       func;
        logic [31:0] delay;
        logic [31:0] tag;
        logic [7:0]  hand;
        bit          typed;
        status_t     st;
        int          held;
    } stim_row_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [95:0] m_tdata;
    logic [2:0]  m_tuser;

    timer_min_heap_scheduler_unit uut (.*);

    always #5 aclk = ~aclk;

    // predictor state
    logic [TICK_W-1:0] pnow;
    logic [TICK_W-1:0] pdl [CAP];
    logic [31:0]       ptag [CAP];
    logic [7:0]        phand [CAP];
    int                pcount;

    timer_result_t result_q [$];
    int  errors = 0;
    int  idle_cycles = 0;
    int  send_pct = 0;
    int  recv_pct = 0;
    logic [31:0] recent_tags [$];

    function automatic void swap_entries(int a, int b);
        logic [TICK_W-1:0] d;
        logic [31:0] t;
        logic [7:0] h;
        d = pdl[a]; pdl[a] = pdl[b]; pdl[b] = d;
        t = ptag[a]; ptag[a] = ptag[b]; ptag[b] = t;
        h = phand[a]; phand[a] = phand[b]; phand[b] = h;
    endfunction

    // sift up: climb while parent deadline is not lower
    function automatic int heap_climb(int i);
        int p;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (pdl[p] < pdl[i]) break;
            swap_entries(i, p);
            i = p;
        end
        return i;
    endfunction

    function automatic int heap_sink(int i);
        int c;
        while (2 * i + 1 < pcount) begin
            c = 2 * i + 1;
            if (c + 1 < pcount && pdl[c + 1] < pdl[c]) c++;
            if (pdl[i] < pdl[c]) break;
            swap_entries(i, c);
            i = c;
        end
        return i;
    endfunction

    function automatic void heap_delete(int i);
        int j;
        pcount--;
        if (i != pcount) begin
            pdl[i] = pdl[pcount]; ptag[i] = ptag[pcount]; phand[i] = phand[pcount];
            j = heap_sink(i);
            j = heap_climb(j);
        end
    endfunction

    function automatic timer_result_t predict_timer(func_t f, logic [31:0] dly,
                                                    logic [31:0] tg, logic [7:0] hd);
        timer_result_t r;
        logic [TICK_W:0] sum;
        int k;
        r = '0;
        r.status = ST_DONE;
        case (f)
            FUNC_INSERT: begin
                if (pcount >= CAP) r.status = ST_FULL;
                else begin
                    sum = {1'b0, pnow} + dly;
                    pdl[pcount] = sum[TICK_W] ? TICK_MAX : sum[TICK_W-1:0];
                    ptag[pcount] = tg; phand[pcount] = hd;
                    pcount++;
                    k = heap_climb(pcount - 1);
                end
            end
            FUNC_REMOVE: begin
                if (pcount == 0) r.status = ST_EMPTY;
                else if (ptag[pcount - 1] == tg) pcount--;
                else begin
                    r.status = ST_NOTFOUND;
                    for (k = 0; k < pcount; k++)
                        if (ptag[k] == tg) begin
                            heap_delete(k);
                            r.status = ST_DONE;
                            break;
                        end
                end
            end
            FUNC_TICK: begin
                pnow = pnow + 1'b1;
                if (pcount == 0) r.status = ST_EMPTY;
                else if (pdl[0] <= pnow) begin
                    r.status = ST_FIRED;
                    r.tag = ptag[0]; r.hand = phand[0];
                    heap_delete(0);
                end else begin
                    r.status = ST_NODUE;
                    r.remain = pdl[0] - pnow;
                end
            end
            default: ;
        endcase
        r.held = pcount[HELD_W-1:0];
        return r;
    endfunction

    // receiver and checker
    always @(posedge aclk) begin
        timer_result_t got, want;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (m_tvalid && m_tready) begin
                got.status = m_tuser;
                got.tag    = m_tdata[31:0];
                got.hand   = m_tdata[39:32];
                got.remain = m_tdata[87:40];
                got.held   = m_tdata[94:88];
                if (result_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected beat %p", got);
                end else begin
                    want = result_q.pop_front();
                    if (got !== want || m_tdata[95] !== 1'b0) begin
                        errors++;
                        if (errors <= 10) $display("mismatch: expected %p got %p", want, got);
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_pct);
        end
    end

    always @(posedge aclk)
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end

    task automatic send_item(func_t f, logic [31:0] dly, logic [31:0] tg, logic [7:0] hd,
                             bit typed, status_t st, int held);
        timer_result_t r;
        while ($urandom_range(99) < send_pct) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= f;
        s_tdata  <= {hd, tg, dly};
        do @(posedge aclk); while (!s_tready);
        r = predict_timer(f, dly, tg, hd);
        if (typed && (r.status != st || r.held != held)) begin
            errors++;
            if (errors <= 10) $display("table row disagrees: %p", r);
        end
        result_q.push_back(r);
        if (f == FUNC_INSERT) recent_tags.push_back(tg);
        if (recent_tags.size() > 80) void'(recent_tags.pop_front());
    endtask

    task automatic drain_results();
        s_tvalid <= 0;
        while (result_q.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    stim_row_t table_rows [$];

    function automatic stim_row_t mk(func_t f, logic [31:0] d, logic [31:0] t,
                                     logic [7:0] h, bit ty, status_t st, int held);
        stim_row_t s;
        s.func = f; s.delay = d; s.tag = t; s.hand = h;
        s.typed = ty; s.st = st; s.held = held;
        return s;
    endfunction

    initial begin
        int n, k, f, mode;
        logic [31:0] tg;
        pnow = '0;
        pcount = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: empty cases, extremes, duplicates, equal deadlines, unused code
        table_rows.push_back(mk(FUNC_TICK, 0, 0, 0, 1, ST_EMPTY, 0));
        table_rows.push_back(mk(FUNC_REMOVE, 0, 32'h1, 0, 1, ST_EMPTY, 0));
        table_rows.push_back(mk(FUNC_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1, ST_DONE, 0));
        table_rows.push_back(mk(FUNC_INSERT, 0, 32'hFFFF_FFFF, 8'hFF, 1, ST_DONE, 1));
        table_rows.push_back(mk(FUNC_INSERT, 32'hFFFF_FFFF, 0, 0, 1, ST_DONE, 2));
        table_rows.push_back(mk(FUNC_INSERT, 3, 32'h55, 8'hA5, 1, ST_DONE, 3));
        table_rows.push_back(mk(FUNC_INSERT, 3, 32'h55, 8'h5A, 1, ST_DONE, 4));
        table_rows.push_back(mk(FUNC_INSERT, 3, 32'h77, 8'h11, 1, ST_DONE, 5));
        table_rows.push_back(mk(FUNC_TICK, 0, 0, 0, 1, ST_FIRED, 4));
        table_rows.push_back(mk(FUNC_TICK, 0, 0, 0, 1, ST_NODUE, 4));
        table_rows.push_back(mk(FUNC_REMOVE, 0, 32'hDEAD, 0, 1, ST_NOTFOUND, 4));
        table_rows.push_back(mk(FUNC_REMOVE, 0, 32'h55, 0, 1, ST_DONE, 3));
        table_rows.push_back(mk(FUNC_TICK, 0, 0, 0, 0, ST_DONE, 0));
        table_rows.push_back(mk(FUNC_TICK, 0, 0, 0, 0, ST_DONE, 0));
        table_rows.push_back(mk(FUNC_REMOVE, 0, 32'h0, 0, 0, ST_DONE, 0));
        table_rows.push_back(mk(FUNC_REMOVE, 0, 32'h77, 0, 0, ST_DONE, 0));
        table_rows.push_back(mk(FUNC_REMOVE, 0, 32'h55, 0, 0, ST_DONE, 0));
        foreach (table_rows[i])
            send_item(table_rows[i].func, table_rows[i].delay, table_rows[i].tag,
                      table_rows[i].hand, table_rows[i].typed, table_rows[i].st,
                      table_rows[i].held);
        drain_results();

        // fill to capacity, then one insert that must be refused
        for (k = 0; k < CAP; k++)
            send_item(FUNC_INSERT, $urandom_range(40), 32'(k), 8'(k), 0, ST_DONE, 0);
        send_item(FUNC_INSERT, 1, 32'hABCD, 1, 1, ST_FULL, CAP);
        // wait for every result before going on
        drain_results();

        for (mode = 0; mode < 4; mode++) begin
            case (mode)
                0: begin send_pct = 0;  recv_pct = 0;  end
                1: begin send_pct = 56; recv_pct = 0;  end
                2: begin send_pct = 0;  recv_pct = 56; end
                default: begin send_pct = 15; recv_pct = 15; end
            endcase
            for (n = 0; n < 440; n++) begin
                f = $urandom_range(99);
                tg = $urandom_range(1, 0) ? $urandom_range(15) : $urandom;
                if (f < 40)
                    send_item(FUNC_INSERT,
                              ($urandom_range(19) == 0) ? $urandom : $urandom_range(30),
                              tg, 8'($urandom), 0, ST_DONE, 0);
                else if (f < 60) begin
                    if (recent_tags.size() != 0 && $urandom_range(3) != 0)
                        tg = recent_tags[$urandom_range(recent_tags.size() - 1)];
                    send_item(FUNC_REMOVE, $urandom, tg, 8'($urandom), 0, ST_DONE, 0);
                end else if (f < 97)
                    send_item(FUNC_TICK, $urandom, $urandom, 8'($urandom), 0, ST_DONE, 0);
                else
                    send_item(FUNC_NONE, $urandom, $urandom, 8'($urandom), 0, ST_DONE, 0);
            end
            drain_results();
        end

        if (errors == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end
endmodule
